// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL files of the Potts unit update block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

`endif

// ===== hdl/pudu_pkg.sv =====
// Types, constants and helper functions of the Potts unit update block.
package pudu_pkg;

    // Unit geometry
    localparam int NUM_STATES  = 7;
    localparam int STATE_W     = 4;
    localparam int DATA_W      = 32;
    localparam int ACC_W       = 40;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Registered max tree over the field sums
    localparam int TREE_LEVELS = $clog2(NUM_STATES);
    localparam int TREE_LEAVES = 1 << TREE_LEVELS;
    localparam int TREE_NODES  = 2 * TREE_LEAVES - 1;

    // Configuration port
    localparam int CFG_IDX_W   = 1;

    localparam logic [STATE_W-1:0] INACTIVE_STATE = STATE_W'(NUM_STATES);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD  = 1'b0,
        CFG_CUE_ENABLE = 1'b1
    } t_cfg_index;

    typedef enum logic {
        KIND_WEIGHT = 1'b0,
        KIND_FINISH = 1'b1
    } t_kind;

    typedef enum logic {
        OP_ACCUM  = 1'b0,
        OP_DECIDE = 1'b1
    } t_op;

    // Input word
    typedef struct packed {
        logic                       kind;
        logic [STATE_W-1:0]         field_state;
        logic signed [DATA_W-1:0]   weight;
        logic signed [DATA_W-1:0]   cue_strength;
        logic [STATE_W-1:0]         cue_state;
        logic                       unit_is_cued;
    } t_in_word;

    // Result word
    typedef struct packed {
        logic [STATE_W-1:0]         new_state;
        logic signed [ACC_W-1:0]    max_field;
    } t_out_word;

    // Classified command handed from front to back
    typedef struct packed {
        t_op                        op;
        logic                       add_cue;
        logic [STATE_W-1:0]         state;
        logic signed [DATA_W-1:0]   value;
    } t_cmd;

    // 40-bit accumulator plus sign-extended 32-bit term, saturating
    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0]  acc,
        input logic signed [DATA_W-1:0] term
    );
        logic signed [ACC_W:0] sum;
        sum = {acc[ACC_W-1], acc} + {{(ACC_W + 1 - DATA_W){term[DATA_W-1]}}, term};
        if (sum[ACC_W] != sum[ACC_W-1]) begin
            sat_add = sum[ACC_W] ? {1'b1, {(ACC_W - 1){1'b0}}}
                                 : {1'b0, {(ACC_W - 1){1'b1}}};
        end else begin
            sat_add = sum[ACC_W-1:0];
        end
    endfunction

endpackage

// ===== hdl/potts_unit_discrete_update_top.sv =====
// Top level of the discrete Potts unit update block.
// A finish word passes through the command queue, the tree leaf registers, the max tree and the output register.
// Throughput: one word per cycle unless the queue is full; each weight word is one saturating add into the field bank.
// The finish path runs through a registered max tree of TREE_LEVELS stages and the output register.
// Reset (synchronous, active low) clears the field sums, the queue, the pipeline valids,
// the threshold and the cue enable; no clearing pass is needed.
module potts_unit_discrete_update_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  pudu_pkg::t_in_word              i_in,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output pudu_pkg::t_out_word             o_out,
    input  logic                            i_cfg_we,
    input  logic [pudu_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pudu_pkg::DATA_W-1:0]     i_cfg_data
);

    logic                               w_push;
    logic                               w_pop;
    logic                               w_full;
    logic                               w_empty;
    pudu_pkg::t_cmd                     w_cmd_in;
    pudu_pkg::t_cmd                     w_cmd_out;
    logic signed [pudu_pkg::DATA_W-1:0] w_threshold;

    pudu_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (w_full),
        .o_push      (w_push),
        .o_cmd       (w_cmd_in),
        .o_threshold (w_threshold)
    );

    pudu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_cmd   (w_cmd_out)
    );

    pudu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (w_empty),
        .i_cmd       (w_cmd_out),
        .o_pop       (w_pop),
        .i_threshold (w_threshold),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

// ===== hdl/pudu_front.sv =====
// Front end: input handshake, configuration registers and word classification.
module pudu_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  pudu_pkg::t_in_word              i_in,
    input  logic                            i_cfg_we,
    input  logic [pudu_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pudu_pkg::DATA_W-1:0]     i_cfg_data,
    input  logic                            i_q_full,
    output logic                            o_push,
    output pudu_pkg::t_cmd                  o_cmd,
    output logic signed [pudu_pkg::DATA_W-1:0] o_threshold
);

    logic signed [pudu_pkg::DATA_W-1:0] r_threshold;
    logic                               r_cue_enable;
    logic                               w_finish;
    logic                               w_state_ok;
    logic                               w_cue_ok;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold  <= '0;
            r_cue_enable <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pudu_pkg::CFG_THRESHOLD:  r_threshold  <= i_cfg_data;
                pudu_pkg::CFG_CUE_ENABLE: r_cue_enable <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_threshold = r_threshold;

    // Classify: out-of-range weight words are dropped here
    assign w_finish   = (i_in.kind == pudu_pkg::KIND_FINISH);
    assign w_state_ok = (i_in.field_state < pudu_pkg::INACTIVE_STATE);
    assign w_cue_ok   = (i_in.cue_state < pudu_pkg::INACTIVE_STATE);

    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full && (w_finish || w_state_ok);

    always_comb begin
        o_cmd.op      = w_finish ? pudu_pkg::OP_DECIDE : pudu_pkg::OP_ACCUM;
        o_cmd.add_cue = w_finish && r_cue_enable && i_in.unit_is_cued && w_cue_ok;
        o_cmd.state   = w_finish ? i_in.cue_state : i_in.field_state;
        o_cmd.value   = w_finish ? i_in.cue_strength : i_in.weight;
    end

endmodule

// ===== hdl/pudu_queue.sv =====
// Short command queue decoupling the front end from the back end.
`include "assert_macros.svh"

module pudu_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  pudu_pkg::t_cmd  i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output pudu_pkg::t_cmd  o_cmd
);

    pudu_pkg::t_cmd                 r_mem [0:pudu_pkg::QUEUE_DEPTH-1];
    logic [pudu_pkg::QPTR_W-1:0]    r_wr_ptr;
    logic [pudu_pkg::QPTR_W-1:0]    r_rd_ptr;
    logic [pudu_pkg::QPTR_W:0]      r_count;
    logic [pudu_pkg::QPTR_W:0]      n_count;

    assign o_full  = (r_count == (pudu_pkg::QPTR_W + 1)'(pudu_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Occupancy
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    // Pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            r_count <= n_count;
        end
    end

    `ASSERT_IMPLIES(a_no_overflow, i_push && !i_pop, !o_full, "push into full queue")
    `ASSERT_IMPLIES(a_no_underflow, i_pop, !o_empty, "pop from empty queue")
    `ASSERT_IMPLIES(a_empty_ptrs, o_empty, r_wr_ptr == r_rd_ptr, "empty queue with unequal pointers")

endmodule

// ===== hdl/pudu_back.sv =====
// Back end: field accumulator bank, registered max tree, threshold decision.
`include "assert_macros.svh"

module pudu_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_q_empty,
    input  pudu_pkg::t_cmd                      i_cmd,
    output logic                                o_pop,
    input  logic signed [pudu_pkg::DATA_W-1:0]  i_threshold,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output pudu_pkg::t_out_word                 o_out
);

    localparam int LEAVES = pudu_pkg::TREE_LEAVES;
    localparam int NODES  = pudu_pkg::TREE_NODES;
    localparam int LEVELS = pudu_pkg::TREE_LEVELS;

    logic signed [pudu_pkg::ACC_W-1:0]  r_acc [0:pudu_pkg::NUM_STATES-1];
    logic signed [pudu_pkg::ACC_W-1:0]  r_val [0:NODES-1];
    logic [pudu_pkg::STATE_W-1:0]       r_idx [0:LEAVES-2];
    logic [pudu_pkg::STATE_W-1:0]       w_idx [0:NODES-1];
    logic [LEVELS:0]                    r_vld;
    logic                               r_out_valid;
    pudu_pkg::t_out_word                r_out;
    pudu_pkg::t_out_word                n_out;

    logic                               w_en;
    logic                               w_take_acc;
    logic                               w_take_dec;
    logic signed [pudu_pkg::ACC_W-1:0]  w_sel;
    logic signed [pudu_pkg::ACC_W-1:0]  w_sum;
    logic signed [pudu_pkg::ACC_W-1:0]  w_thr;

    // Whole back end advances unless a result is held at the output
    assign w_en       = !r_out_valid || i_out_ready;
    assign o_pop      = !i_q_empty && w_en;
    assign w_take_acc = o_pop && (i_cmd.op == pudu_pkg::OP_ACCUM);
    assign w_take_dec = o_pop && (i_cmd.op == pudu_pkg::OP_DECIDE);

    // One shared saturating adder: weight into its field, or cue into its field
    always_comb begin
        w_sel = '0;
        for (int i = 0; i < pudu_pkg::NUM_STATES; i++) begin
            if (i_cmd.state == pudu_pkg::STATE_W'(i)) begin
                w_sel = r_acc[i];
            end
        end
        w_sum = pudu_pkg::sat_add(w_sel, i_cmd.value);
    end

    // Accumulator bank and tree leaves
    for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
        if (i < pudu_pkg::NUM_STATES) begin : g_real
            logic signed [pudu_pkg::ACC_W-1:0] w_field;

            assign w_field = (i_cmd.add_cue && (i_cmd.state == pudu_pkg::STATE_W'(i)))
                             ? w_sum : r_acc[i];

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_acc[i] <= '0;
                end else if (w_take_dec) begin
                    r_acc[i] <= '0;
                end else if (w_take_acc && (i_cmd.state == pudu_pkg::STATE_W'(i))) begin
                    r_acc[i] <= w_sum;
                end
            end

            // Only strictly positive fields compete; others enter as zero
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_val[LEAVES-1+i] <= (!w_field[pudu_pkg::ACC_W-1] && (w_field != '0))
                                         ? w_field : '0;
                end
            end
        end else begin : g_pad
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_val[LEAVES-1+i] <= '0;
                end
            end
        end

        assign w_idx[LEAVES-1+i] = (r_val[LEAVES-1+i] != '0)
                                   ? pudu_pkg::STATE_W'(i) : pudu_pkg::INACTIVE_STATE;
    end

    // Internal tree nodes: left child covers lower states and wins ties
    for (genvar n = 0; n < LEAVES - 1; n++) begin : g_node
        logic w_right;

        assign w_right = (r_val[2*n+2] > r_val[2*n+1]);

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_val[n] <= w_right ? r_val[2*n+2] : r_val[2*n+1];
                r_idx[n] <= w_right ? w_idx[2*n+2] : w_idx[2*n+1];
            end
        end

        assign w_idx[n] = r_idx[n];
    end

    // Decide word tracking through the tree
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LEVELS-1:0], w_take_dec};
        end
    end

    // Threshold compare on the root; tie goes to the active state
    assign w_thr = {{(pudu_pkg::ACC_W - pudu_pkg::DATA_W){i_threshold[pudu_pkg::DATA_W-1]}},
                    i_threshold};

    always_comb begin
        n_out.max_field = r_val[0];
        n_out.new_state = (w_thr > r_val[0]) ? pudu_pkg::INACTIVE_STATE : w_idx[0];
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_vld[LEVELS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && r_vld[LEVELS]) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `ASSERT_IMPLIES(a_state_range, r_out_valid,
        r_out.new_state <= pudu_pkg::INACTIVE_STATE, "new_state out of range")
    `ASSERT_IMPLIES(a_max_nonneg, r_out_valid,
        !r_out.max_field[pudu_pkg::ACC_W-1], "negative max_field")
    `ASSERT_IMPLIES(a_active_pos, r_out_valid && (r_out.new_state != pudu_pkg::INACTIVE_STATE),
        r_out.max_field > 0, "active state without positive field")

endmodule
